/* rtl/core/jte_pkg.sv */
// Shared types and constants for the JSON token emitter.
`timescale 1ns / 1ps

package jte_pkg;

  // Input item kinds carried on in_tuser
  localparam logic [3:0] MODE_OPEN_OBJ  = 4'd0;
  localparam logic [3:0] MODE_CLOSE_OBJ = 4'd1;
  localparam logic [3:0] MODE_OPEN_ARR  = 4'd2;
  localparam logic [3:0] MODE_CLOSE_ARR = 4'd3;
  localparam logic [3:0] MODE_STR_BEGIN = 4'd4;
  localparam logic [3:0] MODE_STR_BYTE  = 4'd5;
  localparam logic [3:0] MODE_STR_END   = 4'd6;
  localparam logic [3:0] MODE_RAW_BEGIN = 4'd7;
  localparam logic [3:0] MODE_RAW_BYTE  = 4'd8;

  // Configuration register indexes
  localparam logic [0:0] REG_FORMAT_ENABLE = 1'd0;
  localparam logic [0:0] REG_INDENT_SIZE   = 1'd1;

  localparam logic [2:0] INDENT_RESET = 3'd4;
  localparam logic [6:0] INDENT_CAP   = 7'd60;

  // Characters of the emitted text
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_LOWER_B   = 8'h62;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_F   = 8'h66;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_LOWER_U   = 8'h75;

  // Control bytes with a short escape letter
  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_HT = 8'h09;
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_FF = 8'h0C;
  localparam logic [7:0] CTL_CR = 8'h0D;

  localparam logic [7:0] CTL_LIMIT = 8'h20;

  // Bytes held for the body of one item, lowest byte sent first
  localparam int unsigned BODY_BYTES = 6;
  typedef logic [BODY_BYTES*8-1:0] body_t;

  // Upper-case hex digit for one nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else begin
      r = 8'h37 + {4'd0, nib};
    end
    return r;
  endfunction

endpackage

/* rtl/core/json_token_emitter.sv */
// JSON token emitter: nesting tracker, separator/indent insertion, string escaping.
//
//   channel | dir | handshake            | payload
//   in_     | in  | in_tvalid/in_tready  | tdata: data_byte ; tuser: mode
//   out_    | out | out_tvalid/out_tready| tdata: out_byte ; tlast: last ; tuser: fault
//   cfg_    | in  | cfg_we               | cfg_index, cfg_wdata
//
// An item is decoded in the cycle it is accepted; its n result bytes then leave one per
// cycle while out_tready is high, from the single output register, driven by a byte
// sequencer (separator, newline, space down-counter, body shift register). in_tready is
// high only while the sequencer is idle.
// Reset is synchronous and clears control state; stack entries are not cleared.
// A low out_tready holds the current byte and stalls the sequencer.
`timescale 1ns / 1ps

module json_token_emitter #(
  parameter int unsigned MAX_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic [3:0] in_tuser,   // [3:0] mode
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  output logic       out_tuser,  // [0] fault
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [2:0] cfg_wdata
);

  localparam int unsigned NDW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned DW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [NDW-1:0]   depth_r, depth_nxt;
  logic             root_r, root_nxt;
  logic             fmt_r;
  logic [2:0]       indent_r;

  // nesting stack, contents undefined until pushed
  logic             lvl_arr_r [MAX_DEPTH];
  logic [1:0]       lvl_cnt_r [MAX_DEPTH];

  // emission plan
  logic             sep_pend_r, sep_pend_nxt;
  logic [7:0]       sep_byte_r, sep_byte_nxt;
  logic             nl_pend_r, nl_pend_nxt;
  logic [5:0]       sp_cnt_r, sp_cnt_nxt;
  jte_pkg::body_t   body_r, body_nxt;
  logic [2:0]       body_left_r, body_left_nxt;
  logic             fault_r, fault_nxt;

  // output register
  logic             out_tvalid_r, out_tvalid_nxt;
  logic [7:0]       out_tdata_r, out_tdata_nxt;
  logic             out_tlast_r, out_tlast_nxt;
  logic             out_tuser_r, out_tuser_nxt;

  logic             in_acc;
  logic             out_load;
  logic [NDW-1:0]   depth_m1;
  logic [DW-1:0]    top_idx;
  logic [DW-1:0]    push_idx;
  logic             top_arr;
  logic             top_odd;
  logic             top_nz;
  logic             ok_str;
  logic             ok_val;
  logic             is_close;
  logic [NDW-1:0]   nl_depth;
  logic [6:0]       sp_full;
  logic [5:0]       spaces;
  logic             push_we;
  logic             push_arr;
  logic             top_we;
  logic             do_prefix;
  logic             do_fault;
  logic [7:0]       c;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_load   = (state_r == S_EMIT) && (!out_tvalid_r || out_tready);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

  // top of stack
  assign depth_m1 = depth_r - NDW'(1);
  assign top_idx  = depth_m1[DW-1:0];
  assign push_idx = depth_r[DW-1:0];
  assign top_arr  = lvl_arr_r[top_idx];
  assign top_odd  = lvl_cnt_r[top_idx][0];
  assign top_nz   = lvl_cnt_r[top_idx][1];

  // value may start here: no second root, and objects want a string key
  assign ok_str = (depth_r == '0) ? !root_r : 1'b1;
  assign ok_val = (depth_r == '0) ? !root_r : (top_arr || top_odd);

  // indentation for the newline: closers use the depth left after the pop
  assign is_close = (in_tuser == jte_pkg::MODE_CLOSE_OBJ) ||
                    (in_tuser == jte_pkg::MODE_CLOSE_ARR);
  assign nl_depth = is_close ? depth_m1 : depth_r;
  assign sp_full  = 7'(nl_depth) * {4'd0, indent_r};
  assign spaces   = (sp_full > jte_pkg::INDENT_CAP) ? jte_pkg::INDENT_CAP[5:0] : sp_full[5:0];

  assign c = in_tdata;

  always_comb begin
    state_nxt      = state_r;
    depth_nxt      = depth_r;
    root_nxt       = root_r;
    sep_pend_nxt   = sep_pend_r;
    sep_byte_nxt   = sep_byte_r;
    nl_pend_nxt    = nl_pend_r;
    sp_cnt_nxt     = sp_cnt_r;
    body_nxt       = body_r;
    body_left_nxt  = body_left_r;
    fault_nxt      = fault_r;
    push_we        = 1'b0;
    push_arr       = 1'b0;
    top_we         = 1'b0;
    do_prefix      = 1'b0;
    do_fault       = 1'b0;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;
    out_tuser_nxt  = out_tuser_r;

    if (state_r == S_IDLE) begin
      if (in_acc) begin
        // decode the item into an emission plan
        sep_pend_nxt  = 1'b0;
        nl_pend_nxt   = 1'b0;
        sp_cnt_nxt    = '0;
        body_nxt      = '0;
        body_left_nxt = '0;
        fault_nxt     = 1'b0;
        case (in_tuser)
          jte_pkg::MODE_OPEN_OBJ, jte_pkg::MODE_OPEN_ARR: begin
            if (depth_r >= NDW'(MAX_DEPTH) || !ok_val) begin
              do_fault = 1'b1;
            end else begin
              do_prefix     = 1'b1;
              push_we       = 1'b1;
              push_arr      = (in_tuser == jte_pkg::MODE_OPEN_ARR);
              depth_nxt     = depth_r + NDW'(1);
              body_nxt[7:0] = push_arr ? jte_pkg::CH_LBRACKET : jte_pkg::CH_LBRACE;
              body_left_nxt = 3'd1;
            end
          end
          jte_pkg::MODE_CLOSE_OBJ, jte_pkg::MODE_CLOSE_ARR: begin
            if (depth_r == '0 ||
                top_arr != (in_tuser == jte_pkg::MODE_CLOSE_ARR) ||
                (in_tuser == jte_pkg::MODE_CLOSE_OBJ && top_odd)) begin
              do_fault = 1'b1;
            end else begin
              depth_nxt     = depth_m1;
              nl_pend_nxt   = fmt_r;
              sp_cnt_nxt    = fmt_r ? spaces : 6'd0;
              body_nxt[7:0] = (in_tuser == jte_pkg::MODE_CLOSE_ARR) ?
                              jte_pkg::CH_RBRACKET : jte_pkg::CH_RBRACE;
              body_left_nxt = 3'd1;
            end
          end
          jte_pkg::MODE_STR_BEGIN: begin
            if (!ok_str) begin
              do_fault = 1'b1;
            end else begin
              do_prefix     = 1'b1;
              body_nxt[7:0] = jte_pkg::CH_QUOTE;
              body_left_nxt = 3'd1;
            end
          end
          jte_pkg::MODE_STR_BYTE: begin
            // escape quote, backslash and control bytes
            if (c == jte_pkg::CH_QUOTE || c == jte_pkg::CH_BACKSLASH) begin
              body_nxt[15:0] = {c, jte_pkg::CH_BACKSLASH};
              body_left_nxt  = 3'd2;
            end else if (c < jte_pkg::CTL_LIMIT) begin
              case (c)
                jte_pkg::CTL_BS: begin
                  body_nxt[15:0] = {jte_pkg::CH_LOWER_B, jte_pkg::CH_BACKSLASH};
                  body_left_nxt  = 3'd2;
                end
                jte_pkg::CTL_HT: begin
                  body_nxt[15:0] = {jte_pkg::CH_LOWER_T, jte_pkg::CH_BACKSLASH};
                  body_left_nxt  = 3'd2;
                end
                jte_pkg::CTL_LF: begin
                  body_nxt[15:0] = {jte_pkg::CH_LOWER_N, jte_pkg::CH_BACKSLASH};
                  body_left_nxt  = 3'd2;
                end
                jte_pkg::CTL_FF: begin
                  body_nxt[15:0] = {jte_pkg::CH_LOWER_F, jte_pkg::CH_BACKSLASH};
                  body_left_nxt  = 3'd2;
                end
                jte_pkg::CTL_CR: begin
                  body_nxt[15:0] = {jte_pkg::CH_LOWER_R, jte_pkg::CH_BACKSLASH};
                  body_left_nxt  = 3'd2;
                end
                default: begin
                  body_nxt      = {jte_pkg::hex_char(c[3:0]), jte_pkg::hex_char(c[7:4]),
                                   jte_pkg::CH_ZERO, jte_pkg::CH_ZERO,
                                   jte_pkg::CH_LOWER_U, jte_pkg::CH_BACKSLASH};
                  body_left_nxt = 3'd6;
                end
              endcase
            end else begin
              body_nxt[7:0] = c;
              body_left_nxt = 3'd1;
            end
          end
          jte_pkg::MODE_STR_END: begin
            body_nxt[7:0] = jte_pkg::CH_QUOTE;
            body_left_nxt = 3'd1;
          end
          jte_pkg::MODE_RAW_BEGIN: begin
            if (!ok_val) begin
              do_fault = 1'b1;
            end else begin
              do_prefix = 1'b1;
            end
          end
          jte_pkg::MODE_RAW_BYTE: begin
            body_nxt[7:0] = c;
            body_left_nxt = 3'd1;
          end
          default: begin
          end
        endcase

        // separator, newline and indent ahead of a value
        if (do_prefix) begin
          if (depth_r == '0) begin
            root_nxt = 1'b1;
          end else begin
            sep_pend_nxt = top_nz;
            sep_byte_nxt = (!top_arr && top_odd) ? jte_pkg::CH_COLON : jte_pkg::CH_COMMA;
            nl_pend_nxt  = fmt_r && (!top_nz || top_arr || !top_odd);
            sp_cnt_nxt   = (fmt_r && (!top_nz || top_arr || !top_odd)) ? spaces : 6'd0;
            top_we       = 1'b1;
          end
        end

        // drop the item: one zero byte marked as a fault
        if (do_fault) begin
          body_nxt      = '0;
          body_left_nxt = 3'd1;
          fault_nxt     = 1'b1;
        end

        if (sep_pend_nxt || nl_pend_nxt || body_left_nxt != 3'd0) begin
          state_nxt = S_EMIT;
        end
      end
    end else if (out_load) begin
      // send the next byte of the plan
      out_tvalid_nxt = 1'b1;
      out_tuser_nxt  = 1'b0;
      if (sep_pend_r) begin
        out_tdata_nxt = sep_byte_r;
        out_tlast_nxt = !nl_pend_r && body_left_r == 3'd0;
        sep_pend_nxt  = 1'b0;
      end else if (nl_pend_r) begin
        out_tdata_nxt = jte_pkg::CH_NEWLINE;
        out_tlast_nxt = sp_cnt_r == 6'd0 && body_left_r == 3'd0;
        nl_pend_nxt   = 1'b0;
      end else if (sp_cnt_r != 6'd0) begin
        out_tdata_nxt = jte_pkg::CH_SPACE;
        out_tlast_nxt = sp_cnt_r == 6'd1 && body_left_r == 3'd0;
        sp_cnt_nxt    = sp_cnt_r - 6'd1;
      end else begin
        out_tdata_nxt = body_r[7:0];
        out_tlast_nxt = body_left_r == 3'd1;
        out_tuser_nxt = fault_r;
        body_nxt      = body_r >> 8;
        body_left_nxt = body_left_r - 3'd1;
      end
      if (out_tlast_nxt) begin
        state_nxt = S_IDLE;
      end
    end
  end

  // hold state, configuration, plan and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      depth_r      <= '0;
      root_r       <= 1'b0;
      fmt_r        <= 1'b0;
      indent_r     <= jte_pkg::INDENT_RESET;
      sep_pend_r   <= 1'b0;
      nl_pend_r    <= 1'b0;
      sp_cnt_r     <= '0;
      body_left_r  <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      depth_r      <= depth_nxt;
      root_r       <= root_nxt;
      sep_pend_r   <= sep_pend_nxt;
      nl_pend_r    <= nl_pend_nxt;
      sp_cnt_r     <= sp_cnt_nxt;
      body_left_r  <= body_left_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          jte_pkg::REG_FORMAT_ENABLE: fmt_r    <= cfg_wdata[0];
          jte_pkg::REG_INDENT_SIZE:   indent_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
    sep_byte_r  <= sep_byte_nxt;
    body_r      <= body_nxt;
    fault_r     <= fault_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  // update the nesting stack: new level on push, count flags of the enclosing level
  always_ff @(posedge clk) begin
    if (top_we) begin
      lvl_cnt_r[top_idx] <= {1'b1, !top_odd};
    end
    if (push_we) begin
      lvl_arr_r[push_idx] <= push_arr;
      lvl_cnt_r[push_idx] <= 2'b00;
    end
  end

endmodule

/* tb/tb_json_token_emitter.sv */
// Self-checking testbench for the JSON token emitter: directed rule cases, then random documents.
`timescale 1ns / 1ps

module tb_json_token_emitter;

  localparam int unsigned STACK_DEPTH = 8;
  localparam int unsigned INDENT_LIMIT = 60;
  localparam logic [3:0] MODE_UNUSED_LO = 4'd9;
  localparam logic [3:0] MODE_UNUSED_HI = 4'd15;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_DIGIT_ONE = 8'h31;

  // One emitted byte as the block should present it
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       fault;
  } text_byte_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] data_byte
  logic [3:0] in_tuser;   // [3:0] mode
  logic       out_tvalid;
  logic       out_tready = 1'b1;
  logic [7:0] out_tdata;  // [7:0] out_byte
  logic       out_tlast;
  logic       out_tuser;  // [0] fault
  logic       cfg_we;
  logic [0:0] cfg_index;
  logic [2:0] cfg_wdata;

  // Predicted nesting state and register copies
  bit          lvl_arr [STACK_DEPTH];
  logic [1:0]  lvl_cnt [STACK_DEPTH];  // [0] odd count, [1] nonzero count
  int unsigned depth;
  bit          root_done;
  bit          fmt_on;
  logic [2:0]  indent;

  text_byte_t  item_text[$];
  text_byte_t  text_due[$];
  int unsigned errors;
  int unsigned items_sent;
  bit          tx_idle_on;
  bit          rx_idle_on;

  json_token_emitter #(
    .MAX_DEPTH(STACK_DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_error(input string what);
    errors++;
    if (errors <= 10) begin
      $display("ERROR at %0t: %s", $time, what);
    end
  endtask

  // ---------------------------------------------------------------- text prediction

  task automatic put_char(input logic [7:0] c);
    text_byte_t b;
    b.ch    = c;
    b.last  = 1'b0;
    b.fault = 1'b0;
    item_text = {item_text, b};
  endtask

  task automatic put_newline(input int unsigned lvl);
    int unsigned spaces;
    spaces = lvl * indent;
    if (spaces > INDENT_LIMIT) begin
      spaces = INDENT_LIMIT;
    end
    put_char(jte_pkg::CH_NEWLINE);
    repeat (spaces) put_char(jte_pkg::CH_SPACE);
  endtask

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return jte_pkg::CH_ZERO + {4'd0, nib};
    end
    return CH_UPPER_A + {4'd0, nib} - 8'd10;
  endfunction

  // Quote and backslash get a backslash; control bytes get a letter or \u00XX
  task automatic put_escaped(input logic [7:0] c);
    if (c == jte_pkg::CH_QUOTE || c == jte_pkg::CH_BACKSLASH) begin
      put_char(jte_pkg::CH_BACKSLASH);
      put_char(c);
    end else if (c < jte_pkg::CTL_LIMIT) begin
      put_char(jte_pkg::CH_BACKSLASH);
      case (c)
        jte_pkg::CTL_BS: put_char(jte_pkg::CH_LOWER_B);
        jte_pkg::CTL_HT: put_char(jte_pkg::CH_LOWER_T);
        jte_pkg::CTL_LF: put_char(jte_pkg::CH_LOWER_N);
        jte_pkg::CTL_FF: put_char(jte_pkg::CH_LOWER_F);
        jte_pkg::CTL_CR: put_char(jte_pkg::CH_LOWER_R);
        default: begin
          put_char(jte_pkg::CH_LOWER_U);
          put_char(jte_pkg::CH_ZERO);
          put_char(jte_pkg::CH_ZERO);
          put_char(hex_digit(c[7:4]));
          put_char(hex_digit(c[3:0]));
        end
      endcase
    end else begin
      put_char(c);
    end
  endtask

  // A value may start unless a second root is begun or an object wants a string key
  function automatic bit value_ok(input bit is_string);
    int unsigned top;
    if (depth == 0) begin
      return !root_done;
    end
    top = depth - 1;
    if (!lvl_arr[top] && !lvl_cnt[top][0] && !is_string) begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic value_separator();
    int unsigned top;
    logic [1:0]  cnt;
    bit          arr;
    if (depth == 0) begin
      root_done = 1'b1;
    end else begin
      top = depth - 1;
      cnt = lvl_cnt[top];
      arr = lvl_arr[top];
      // comma between values, colon between a key and its value
      if (cnt[1]) begin
        put_char((!arr && cnt[0]) ? jte_pkg::CH_COLON : jte_pkg::CH_COMMA);
      end
      // a value that follows its key stays on the key's line
      if (fmt_on && (!cnt[1] || arr || !cnt[0])) begin
        put_newline(depth);
      end
      lvl_cnt[top] = {1'b1, ~cnt[0]};
    end
  endtask

  // Work out the bytes one request causes and queue them for the checker
  task automatic emit_text(input logic [3:0] mode, input logic [7:0] data);
    bit          refused;
    bit          want_arr;
    int unsigned top;
    text_byte_t  tail;
    item_text.delete();
    refused = 1'b0;
    case (mode)
      jte_pkg::MODE_OPEN_OBJ, jte_pkg::MODE_OPEN_ARR: begin
        if (depth >= STACK_DEPTH || !value_ok(1'b0)) begin
          refused = 1'b1;
        end else begin
          value_separator();
          lvl_arr[depth] = (mode == jte_pkg::MODE_OPEN_ARR);
          lvl_cnt[depth] = 2'b00;
          depth++;
          put_char((mode == jte_pkg::MODE_OPEN_ARR) ? jte_pkg::CH_LBRACKET :
                                                     jte_pkg::CH_LBRACE);
        end
      end
      jte_pkg::MODE_CLOSE_OBJ, jte_pkg::MODE_CLOSE_ARR: begin
        want_arr = (mode == jte_pkg::MODE_CLOSE_ARR);
        if (depth == 0) begin
          refused = 1'b1;
        end else begin
          top = depth - 1;
          if (lvl_arr[top] != want_arr || (!want_arr && lvl_cnt[top][0])) begin
            refused = 1'b1;
          end else begin
            depth--;
            if (fmt_on) begin
              put_newline(depth);
            end
            put_char(want_arr ? jte_pkg::CH_RBRACKET : jte_pkg::CH_RBRACE);
          end
        end
      end
      jte_pkg::MODE_STR_BEGIN: begin
        if (!value_ok(1'b1)) begin
          refused = 1'b1;
        end else begin
          value_separator();
          put_char(jte_pkg::CH_QUOTE);
        end
      end
      jte_pkg::MODE_STR_BYTE: put_escaped(data);
      jte_pkg::MODE_STR_END: put_char(jte_pkg::CH_QUOTE);
      jte_pkg::MODE_RAW_BEGIN: begin
        if (!value_ok(1'b0)) begin
          refused = 1'b1;
        end else begin
          value_separator();
        end
      end
      jte_pkg::MODE_RAW_BYTE: put_char(data);
      default: ;
    endcase
    if (refused) begin
      tail.ch    = 8'h00;
      tail.last  = 1'b1;
      tail.fault = 1'b1;
      item_text  = {tail};
    end else if (item_text.size() != 0) begin
      tail = item_text[item_text.size() - 1];
      tail.last = 1'b1;
      item_text[item_text.size() - 1] = tail;
    end
    text_due = {text_due, item_text};
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin : check_text
    text_byte_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (text_due.size() == 0) begin
        flag_error($sformatf("unexpected byte %02h last %b fault %b",
                             out_tdata, out_tlast, out_tuser));
      end else begin
        want = text_due.pop_front();
        if (out_tdata !== want.ch || out_tlast !== want.last || out_tuser !== want.fault) begin
          flag_error($sformatf("byte %02h last %b fault %b, wanted %02h last %b fault %b",
                               out_tdata, out_tlast, out_tuser,
                               want.ch, want.last, want.fault));
        end
      end
    end
  end

  // Receiver: stall for a drawn number of cycles after each accepted byte
  initial begin : out_pacing
    int unsigned stall;
    forever begin
      @(posedge clk);
      if (out_tvalid === 1'b1 && out_tready) begin
        stall = rx_idle_on ? $urandom_range(0, 15) : 0;
        if (stall != 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
          out_tready <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus helpers

  // Offer one request after a drawn gap; valid stays high for a back-to-back follower
  task automatic send_item(input logic [3:0] mode, input logic [7:0] data);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= data;
    do @(posedge clk); while (in_tready !== 1'b1);
    emit_text(mode, data);
    if (mode <= jte_pkg::MODE_RAW_BYTE) begin
      items_sent++;
    end
  endtask

  // Hold the sender until all predicted bytes are out and the block is idle
  task automatic drain_output();
    in_tvalid <= 1'b0;
    while (text_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [2:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == jte_pkg::REG_FORMAT_ENABLE) begin
      fmt_on = val[0];
    end else begin
      indent = val;
    end
    @(posedge clk);
  endtask

  // Favour bytes that need escaping
  function automatic logic [7:0] text_byte();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 31));
      1: return ($urandom_range(0, 1) != 0) ? jte_pkg::CH_QUOTE : jte_pkg::CH_BACKSLASH;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_string();
    int unsigned len;
    len = $urandom_range(0, 4);
    send_item(jte_pkg::MODE_STR_BEGIN, 8'($urandom_range(0, 255)));
    repeat (len) send_item(jte_pkg::MODE_STR_BYTE, text_byte());
    send_item(jte_pkg::MODE_STR_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_raw();
    int unsigned len;
    len = $urandom_range(1, 3);
    send_item(jte_pkg::MODE_RAW_BEGIN, 8'($urandom_range(0, 255)));
    repeat (len) send_item(jte_pkg::MODE_RAW_BYTE, 8'($urandom_range(0, 255)));
  endtask

  // Random walk through well-formed JSON below the root, with some noise mixed in
  task automatic walk_json(input int unsigned quota);
    int unsigned first;
    int unsigned top;
    int unsigned pick;
    logic [3:0]  m;
    first = items_sent;
    while (items_sent - first < quota && depth != 0) begin
      top = depth - 1;
      if ($urandom_range(0, 9) == 0) begin
        // noise: any kind and byte, but never close the root
        m = 4'($urandom_range(0, 15));
        if (m == jte_pkg::MODE_CLOSE_ARR && depth == 1) begin
          m = jte_pkg::MODE_RAW_BYTE;
        end
        send_item(m, 8'($urandom_range(0, 255)));
      end else if (!lvl_arr[top] && !lvl_cnt[top][0]) begin
        // object waiting for a key
        if ($urandom_range(0, 3) == 0) begin
          send_item(jte_pkg::MODE_CLOSE_OBJ, 8'($urandom_range(0, 255)));
        end else begin
          send_string();
        end
      end else begin
        pick = $urandom_range(0, 9);
        if (pick <= 2) begin
          send_string();
        end else if (pick <= 4) begin
          send_raw();
        end else if (pick == 5) begin
          send_item(jte_pkg::MODE_OPEN_OBJ, 8'($urandom_range(0, 255)));
        end else if (pick == 6) begin
          send_item(jte_pkg::MODE_OPEN_ARR, 8'($urandom_range(0, 255)));
        end else if (lvl_arr[top] && depth > 1) begin
          send_item(jte_pkg::MODE_CLOSE_ARR, 8'($urandom_range(0, 255)));
        end else if (!lvl_arr[top]) begin
          send_string();
        end else begin
          send_raw();
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- tests

  // Root array, escapes and the nesting rules with formatting off
  task automatic test_escapes_and_rules();
    logic [7:0] specials [10];
    specials = '{8'h00, jte_pkg::CTL_BS, jte_pkg::CTL_HT, jte_pkg::CTL_LF, jte_pkg::CTL_FF,
                 jte_pkg::CTL_CR, 8'h1F, 8'h7F, 8'hFF, 8'h41};
    write_reg(jte_pkg::REG_FORMAT_ENABLE, 3'd0);
    send_item(jte_pkg::MODE_OPEN_ARR, 8'h00);
    // first array element needs no separator, so the raw begin is silent
    send_item(jte_pkg::MODE_RAW_BEGIN, 8'h00);
    send_item(jte_pkg::MODE_RAW_BYTE, 8'h00);
    send_item(jte_pkg::MODE_RAW_BYTE, 8'hFF);
    send_item(jte_pkg::MODE_OPEN_OBJ, 8'hFF);
    // non-string keys and a closer of the wrong kind
    send_item(jte_pkg::MODE_RAW_BEGIN, 8'h00);
    send_item(jte_pkg::MODE_OPEN_ARR, 8'h00);
    send_item(jte_pkg::MODE_CLOSE_ARR, 8'h00);
    send_item(jte_pkg::MODE_STR_BEGIN, 8'h00);
    send_item(jte_pkg::MODE_STR_BYTE, jte_pkg::CH_QUOTE);
    send_item(jte_pkg::MODE_STR_BYTE, jte_pkg::CH_BACKSLASH);
    send_item(jte_pkg::MODE_STR_END, 8'h00);
    // object close while the key waits for its value
    send_item(jte_pkg::MODE_CLOSE_OBJ, 8'h00);
    send_item(jte_pkg::MODE_STR_BEGIN, 8'h00);
    foreach (specials[i]) send_item(jte_pkg::MODE_STR_BYTE, specials[i]);
    send_item(jte_pkg::MODE_STR_END, 8'h00);
    send_item(jte_pkg::MODE_CLOSE_OBJ, 8'h00);
    // stray string end outside any string, and ignored modes
    send_item(jte_pkg::MODE_STR_END, 8'h00);
    send_item(MODE_UNUSED_LO, 8'h55);
    send_item(MODE_UNUSED_HI, 8'hAA);
  endtask

  // Fill the stack with the widest indentation, overflow it, then unwind
  task automatic test_nesting_overflow();
    drain_output();
    write_reg(jte_pkg::REG_FORMAT_ENABLE, 3'd1);
    write_reg(jte_pkg::REG_INDENT_SIZE, 3'd7);
    while (depth < STACK_DEPTH) send_item(jte_pkg::MODE_OPEN_ARR, 8'h00);
    send_item(jte_pkg::MODE_OPEN_OBJ, 8'h00);
    send_item(jte_pkg::MODE_OPEN_ARR, 8'h00);
    send_string();
    send_item(jte_pkg::MODE_OPEN_OBJ, 8'h00);
    send_item(jte_pkg::MODE_STR_BEGIN, 8'h00);
    send_item(jte_pkg::MODE_STR_END, 8'h00);
    send_raw();
    send_item(jte_pkg::MODE_CLOSE_OBJ, 8'h00);
    while (depth > 1) send_item(jte_pkg::MODE_CLOSE_ARR, 8'h00);
  endtask

  task automatic test_random_compact();
    drain_output();
    write_reg(jte_pkg::REG_FORMAT_ENABLE, 3'd0);
    write_reg(jte_pkg::REG_INDENT_SIZE, 3'd0);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    walk_json(70);
  endtask

  task automatic test_random_indented();
    drain_output();
    write_reg(jte_pkg::REG_FORMAT_ENABLE, 3'd1);
    write_reg(jte_pkg::REG_INDENT_SIZE, 3'($urandom_range(1, 6)));
    walk_json(40);
    drain_output();
    write_reg(jte_pkg::REG_INDENT_SIZE, 3'd7);
    walk_json(40);
  endtask

  // No idling on either side, formatting on with zero indentation
  task automatic test_random_unpaced();
    drain_output();
    write_reg(jte_pkg::REG_INDENT_SIZE, 3'd0);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    walk_json(40);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Close everything including the root, then break the depth-zero rules
  task automatic test_unwind_and_root();
    drain_output();
    write_reg(jte_pkg::REG_INDENT_SIZE, 3'd3);
    while (depth > 0) begin
      if (!lvl_arr[depth - 1] && lvl_cnt[depth - 1][0]) begin
        send_item(jte_pkg::MODE_RAW_BEGIN, 8'h00);
        send_item(jte_pkg::MODE_RAW_BYTE, CH_DIGIT_ONE);
      end
      send_item(lvl_arr[depth - 1] ? jte_pkg::MODE_CLOSE_ARR : jte_pkg::MODE_CLOSE_OBJ, 8'h00);
    end
    send_item(jte_pkg::MODE_CLOSE_ARR, 8'h00);
    send_item(jte_pkg::MODE_CLOSE_OBJ, 8'h00);
    send_item(jte_pkg::MODE_OPEN_OBJ, 8'h00);
    send_item(jte_pkg::MODE_OPEN_ARR, 8'h00);
    send_item(jte_pkg::MODE_RAW_BEGIN, 8'h00);
    send_item(jte_pkg::MODE_STR_BEGIN, 8'h00);
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'h00;
    in_tuser   = jte_pkg::MODE_OPEN_OBJ;
    cfg_we     = 1'b0;
    cfg_index  = jte_pkg::REG_FORMAT_ENABLE;
    cfg_wdata  = 3'd0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    errors     = 0;
    items_sent = 0;
    depth      = 0;
    root_done  = 1'b0;
    fmt_on     = 1'b0;
    indent     = jte_pkg::INDENT_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_escapes_and_rules();
    test_nesting_overflow();
    test_random_compact();
    test_random_indented();
    test_random_unpaced();
    test_unwind_and_root();

    drain_output();
    repeat (20) @(posedge clk);
    if (text_due.size() != 0) begin
      flag_error($sformatf("%0d bytes never arrived", text_due.size()));
    end
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop for a hung handshake
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/jte_pkg.sv
rtl/core/json_token_emitter.sv
tb/tb_json_token_emitter.sv
